### hw/rtl/udrf_pkg.sv
// Shared types and constants for the dual serial-port ring buffer block.
// Used by the ring module, the top level and the port checker; no dependencies.
`default_nettype none

package udrf_pkg;

  localparam int RX_DEPTH_DEF = 16;
  localparam int TX_DEPTH_DEF = 16;

  // Width of the fill counts that every result carries.
  localparam int COUNT_W = 4;

  // Command codes.
  localparam logic [2:0] CMD_RX_BYTE   = 3'd0;
  localparam logic [2:0] CMD_TX_PUT    = 3'd1;
  localparam logic [2:0] CMD_TX_READY  = 3'd2;
  localparam logic [2:0] CMD_RX_READ   = 3'd3;
  localparam logic [2:0] CMD_CLEAR_ERR = 3'd4;
  localparam logic [2:0] CMD_RESET_PTR = 3'd5;

  // Bit positions in the sticky error flags.
  localparam int ERR_RX_FULL = 0;
  localparam int ERR_TX_FULL = 1;
  localparam int ERR_NO_DATA = 2;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] byte_in;
    logic [2:0] clear_mask;
  } req_t;

  typedef struct packed {
    logic [7:0]         read_byte;
    logic               send_valid;
    logic [7:0]         send_byte;
    logic               tx_irq_enable;
    logic [COUNT_W-1:0] rx_waiting;
    logic [COUNT_W-1:0] tx_waiting;
    logic [2:0]         error_bits;
  } resp_t;

  // Operation strobes from the controller to one ring.
  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
  } ring_ctl_t;

  // Status from one ring back to the controller.
  typedef struct packed {
    logic               full;
    logic               empty;
    logic [COUNT_W-1:0] count;
  } ring_stat_t;

endpackage

`default_nettype wire

### hw/rtl/udrf_ring.sv
// One ring buffer: a synchronous byte memory plus its read and write pointers.
// Depends on udrf_pkg for the control and status structs.
`default_nettype none

module udrf_ring #(
  parameter int DEPTH = udrf_pkg::RX_DEPTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire udrf_pkg::ring_ctl_t   ctl,
  input  wire logic [7:0]            wdata,
  output      udrf_pkg::ring_stat_t  stat,
  output      logic [7:0]            rdata
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = PTR_W + 1;
  localparam int CW    = udrf_pkg::COUNT_W;

  logic [7:0]       mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W-1:0] wr_ptr_inc;
  logic [PTR_W-1:0] rd_ptr_inc;
  logic [CNT_W-1:0] fill;
  logic [CNT_W+CW-1:0] fill_ext;

  // The pointer is advanced first; the slot it then names is the one used.
  assign wr_ptr_inc = (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
  assign rd_ptr_inc = (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;

  always_comb begin
    if (wr_ptr >= rd_ptr) begin
      fill = {1'b0, wr_ptr} - {1'b0, rd_ptr};
    end else begin
      fill = CNT_W'(DEPTH) - {1'b0, rd_ptr} + {1'b0, wr_ptr};
    end
    fill_ext = {{CW{1'b0}}, fill};
  end

  assign stat.full  = (wr_ptr_inc == rd_ptr);
  assign stat.empty = (wr_ptr == rd_ptr);
  assign stat.count = fill_ext[CW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else if (ctl.clear) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      if (ctl.push && !stat.full) begin
        wr_ptr <= wr_ptr_inc;
      end
      if (ctl.pop && !stat.empty) begin
        rd_ptr <= rd_ptr_inc;
      end
    end
  end

  // The next slot to be read is fetched every cycle; the controller only
  // keeps the word from the cycle in which it popped.
  always_ff @(posedge clk) begin
    if (ctl.push && !stat.full) begin
      mem[wr_ptr_inc] <= wdata;
    end
    rdata <= mem[rd_ptr_inc];
  end

endmodule

`default_nettype wire

### hw/rtl/uart_dual_ring_fifo_top.sv
// Top level of the dual serial-port ring buffer block: request decode, flags,
// result register. Depends on udrf_pkg and instantiates udrf_ring twice.
//
// Usage: one request channel (req_valid, req_stall, req_data) carries a command
// with a byte and an error clear mask; one response channel (resp_valid,
// resp_stall, resp_data) returns exactly one result for every request.
// A request is taken at a clock edge where req_valid is high and req_stall low.
// Each ring keeps one slot free, so it holds RX_DEPTH-1 or TX_DEPTH-1 bytes.
// The accepting edge performs the ring access (pointer update, memory write or
// the memory read of the slot being popped); the next edge loads the result
// register from the registered memory read data and the updated pointers and
// flags, and raises resp_valid.
// A new request is not taken while the last one is in its ring access, as the
// ring memories have a registered read. A new request is taken while a finished
// result is being handed off, as long as the receiver is not stalling it.
// Reset (rst, synchronous, active high) clears all pointers, the sticky error
// flags, the transmitter-ready interrupt enable and the response valid. The
// ring memories are not cleared; only written slots are ever read back.
// When the receiver holds resp_stall, the result stays put and req_stall rises
// until the result has been taken.
`default_nettype none

module uart_dual_ring_fifo_top #(
  parameter int RX_DEPTH = udrf_pkg::RX_DEPTH_DEF,
  parameter int TX_DEPTH = udrf_pkg::TX_DEPTH_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            req_valid,
  output      logic            req_stall,
  input  wire udrf_pkg::req_t  req_data,
  output      logic            resp_valid,
  input  wire logic            resp_stall,
  output      udrf_pkg::resp_t resp_data
);

  // Controller phases: waiting for a request, or finishing one whose ring
  // access happened at the last edge.
  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_FETCH = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  udrf_pkg::ring_ctl_t  rx_ctl;
  udrf_pkg::ring_ctl_t  tx_ctl;
  udrf_pkg::ring_stat_t rx_stat;
  udrf_pkg::ring_stat_t tx_stat;
  logic [7:0]           rx_rdata;
  logic [7:0]           tx_rdata;

  logic       accept;
  logic       take_resp;
  logic [2:0] sticky_errors;
  logic [2:0] sticky_errors_next;
  logic       ready_irq_on;
  logic       ready_irq_on_next;
  // Which memory word, if any, the pending result must carry.
  logic       read_hit;
  logic       send_hit;

  assign take_resp = resp_valid && !resp_stall;
  // A request waits while a ring access is in flight or while a result that
  // the receiver is stalling still occupies the result register.
  assign req_stall = (state == ST_FETCH) || (resp_valid && resp_stall);
  assign accept    = req_valid && !req_stall;

  // Ring strobes are only issued in the cycle of acceptance.
  always_comb begin
    rx_ctl = '0;
    tx_ctl = '0;
    if (accept) begin
      rx_ctl.push  = (req_data.cmd == udrf_pkg::CMD_RX_BYTE);
      rx_ctl.pop   = (req_data.cmd == udrf_pkg::CMD_RX_READ);
      rx_ctl.clear = (req_data.cmd == udrf_pkg::CMD_RESET_PTR);
      tx_ctl.push  = (req_data.cmd == udrf_pkg::CMD_TX_PUT);
      tx_ctl.pop   = (req_data.cmd == udrf_pkg::CMD_TX_READY);
      tx_ctl.clear = (req_data.cmd == udrf_pkg::CMD_RESET_PTR);
    end
  end

  udrf_ring #(
    .DEPTH (RX_DEPTH)
  ) u_rx_ring (
    .clk   (clk),
    .rst   (rst),
    .ctl   (rx_ctl),
    .wdata (req_data.byte_in),
    .stat  (rx_stat),
    .rdata (rx_rdata)
  );

  udrf_ring #(
    .DEPTH (TX_DEPTH)
  ) u_tx_ring (
    .clk   (clk),
    .rst   (rst),
    .ctl   (tx_ctl),
    .wdata (req_data.byte_in),
    .stat  (tx_stat),
    .rdata (tx_rdata)
  );

  // Sticky flags and the interrupt enable follow the command, judged against
  // the ring status before the access.
  always_comb begin
    sticky_errors_next = sticky_errors;
    ready_irq_on_next  = ready_irq_on;
    if (accept) begin
      case (req_data.cmd)
        udrf_pkg::CMD_RX_BYTE: begin
          if (rx_stat.full) begin
            sticky_errors_next[udrf_pkg::ERR_RX_FULL] = 1'b1;
          end
        end
        udrf_pkg::CMD_TX_PUT: begin
          if (tx_stat.full) begin
            sticky_errors_next[udrf_pkg::ERR_TX_FULL] = 1'b1;
          end
          ready_irq_on_next = 1'b1;
        end
        udrf_pkg::CMD_TX_READY: begin
          if (tx_stat.empty) begin
            ready_irq_on_next = 1'b0;
          end
        end
        udrf_pkg::CMD_RX_READ: begin
          if (rx_stat.empty) begin
            sticky_errors_next[udrf_pkg::ERR_NO_DATA] = 1'b1;
          end
        end
        udrf_pkg::CMD_CLEAR_ERR: begin
          sticky_errors_next = sticky_errors & ~req_data.clear_mask;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_FETCH;
        end
      end
      ST_FETCH: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      sticky_errors <= '0;
      ready_irq_on  <= 1'b0;
      resp_valid    <= 1'b0;
    end else begin
      state         <= state_next;
      sticky_errors <= sticky_errors_next;
      ready_irq_on  <= ready_irq_on_next;
      // The result register is always empty or being drained when a fetch
      // finishes, since acceptance required that.
      if (state == ST_FETCH) begin
        resp_valid <= 1'b1;
      end else if (take_resp) begin
        resp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      read_hit <= (req_data.cmd == udrf_pkg::CMD_RX_READ) && !rx_stat.empty;
      send_hit <= (req_data.cmd == udrf_pkg::CMD_TX_READY) && !tx_stat.empty;
    end
  end

  // In the fetch cycle the pointers and flags already hold their new values
  // and the popped memory word sits in the ring's read register.
  always_ff @(posedge clk) begin
    if (state == ST_FETCH) begin
      resp_data.read_byte     <= read_hit ? rx_rdata : 8'd0;
      resp_data.send_valid    <= send_hit;
      resp_data.send_byte     <= send_hit ? tx_rdata : 8'd0;
      resp_data.tx_irq_enable <= ready_irq_on;
      resp_data.rx_waiting    <= rx_stat.count;
      resp_data.tx_waiting    <= tx_stat.count;
      resp_data.error_bits    <= sticky_errors;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/udrf_checker.sv
// Port-level checker for the dual ring buffer block, bound to the top level.
// Depends on udrf_pkg for the response struct.
`default_nettype none

module udrf_checker (
  input wire logic            clk,
  input wire logic            rst,
  input wire logic            req_valid,
  input wire logic            req_stall,
  input wire logic            resp_valid,
  input wire logic            resp_stall,
  input wire udrf_pkg::resp_t resp_data
);

  logic req_taken;

  assign req_taken = req_valid && !req_stall;

  // A stalled result stays valid and unchanged.
  a_resp_hold: assert property (@(posedge clk) disable iff (rst)
    resp_valid && resp_stall |=> resp_valid && $stable(resp_data))
    else $error("stalled response dropped or changed");

  // Every taken request yields a result once its ring access and result load are done.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    req_taken |-> ##2 resp_valid)
    else $error("response missing two cycles after request");

  // The block does not take a second request while the first is in its ring access.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req_taken |=> req_stall)
    else $error("request taken during ring access");

  // A byte handed to the shifter is flagged; otherwise the field is zero.
  a_send_zero: assert property (@(posedge clk) disable iff (rst)
    resp_valid && !resp_data.send_valid |-> resp_data.send_byte == 8'd0)
    else $error("send byte nonzero without send valid");

endmodule

bind uart_dual_ring_fifo_top udrf_checker u_udrf_checker (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req_valid),
  .req_stall  (req_stall),
  .resp_valid (resp_valid),
  .resp_stall (resp_stall),
  .resp_data  (resp_data)
);

`default_nettype wire
